// File: sv/dtt_pkg.sv
package dtt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int TIME_W      = 64;
    localparam int PER_W       = 32;
    localparam int APB_AW      = 3;

    localparam logic [PER_W-1:0] ROLLOVER_RESET = 32'd3600000;
    localparam logic [APB_AW-1:0] ADDR_ROLLOVER = 3'd0;

    localparam logic [2:0] FUNC_ADD     = 3'd0;
    localparam logic [2:0] FUNC_CANCEL  = 3'd1;
    localparam logic [2:0] FUNC_REFRESH = 3'd2;
    localparam logic [2:0] FUNC_RESET   = 3'd3;
    localparam logic [2:0] FUNC_SCAN    = 3'd4;
    localparam logic [2:0] FUNC_QUERY   = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_CANCEL,
        OP_REFRESH,
        OP_RESET,
        OP_SCAN,
        OP_QUERY,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic [PER_W-1:0]  period;
        logic              reload;
        logic              restart;
        logic [TIME_W-1:0] now;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic              expired;
        logic [TIME_W-1:0] wait_ms;
        logic              notify;
        logic              last;
    } res_t;

    function automatic res_t mk_res(
        input logic [1:0]        status,
        input logic [SLOT_W-1:0] slot,
        input logic              expired,
        input logic [TIME_W-1:0] wait_ms,
        input logic              notify,
        input logic              last
    );
        res_t r;
        r.status  = status;
        r.slot    = slot;
        r.expired = expired;
        r.wait_ms = wait_ms;
        r.notify  = notify;
        r.last    = last;
        return r;
    endfunction

endpackage

// File: sv/dtt_if.sv
interface dtt_req_if;
    import dtt_pkg::*;
    logic                valid;
    logic                ready;
    logic [2:0]          func;
    logic [SLOT_W-1:0]   timer_slot;
    logic [PER_W-1:0]    period_ms;
    logic                reload;
    logic                restart_from_now;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, func, timer_slot, period_ms, reload,
                    restart_from_now, now_ms, input ready);
    modport sink   (input valid, func, timer_slot, period_ms, reload,
                    restart_from_now, now_ms, output ready);
endinterface

interface dtt_rsp_if;
    import dtt_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [SLOT_W-1:0]   result_slot;
    logic                expired_valid;
    logic [TIME_W-1:0]   wait_ms;
    logic                front_notify;
    logic                last;

    modport source (output valid, status, result_slot, expired_valid, wait_ms,
                    front_notify, last, input ready);
    modport sink   (input valid, status, result_slot, expired_valid, wait_ms,
                    front_notify, last, output ready);
endinterface

// File: sv/deadline_timer_table_unit.sv
// Timer table of 16 slots ordered by (deadline, slot). Items enter a
// two-deep command queue and are executed one at a time. Cancel, refresh,
// failed or fast-path reset, an add to a full table, a scan of an empty
// table and unknown codes answer straight from the execute step; other
// adds and queries sweep the table one slot per cycle through the single
// deadline read port, and a reset that rewrites the slot writes it first,
// then sweeps. An expiry scan sweeps once to mark due slots, then sweeps
// again for each expired slot it reports. Results leave through a registered
// output stage; a stalled result holds the executor, not the queue.
// rollover_window sits at APB address 0.
module deadline_timer_table_unit
    import dtt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    dtt_req_if.sink           req,
    dtt_rsp_if.source         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [PER_W-1:0] window_reg, window_next;
    logic             cmd_valid;
    cmd_t             cmd;
    logic             cmd_pop;
    res_t             res;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ROLLOVER) ? window_reg : '0;

    always_comb
    begin
        window_next = window_reg;
        if (psel && penable && pwrite && paddr == ADDR_ROLLOVER)
            window_next = pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= ROLLOVER_RESET;
        else
            window_reg <= window_next;
    end

    dtt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    dtt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .window    (window_reg),
        .res_valid (rsp.valid),
        .res       (res),
        .res_ready (rsp.ready)
    );

    assign rsp.status        = res.status;
    assign rsp.result_slot   = res.slot;
    assign rsp.expired_valid = res.expired;
    assign rsp.wait_ms       = res.wait_ms;
    assign rsp.front_notify  = res.notify;
    assign rsp.last          = res.last;

endmodule

// File: sv/dtt_front.sv
module dtt_front
    import dtt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dtt_req_if.sink     req,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    // two-entry command queue
    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       in_cmd;
    logic       push;

    always_comb
    begin
        in_cmd.slot     = req.timer_slot;
        in_cmd.period   = req.period_ms;
        in_cmd.reload   = req.reload;
        in_cmd.restart  = req.restart_from_now;
        in_cmd.now      = req.now_ms;
        unique case (req.func)
            FUNC_ADD:     in_cmd.op = OP_ADD;
            FUNC_CANCEL:  in_cmd.op = OP_CANCEL;
            FUNC_REFRESH: in_cmd.op = OP_REFRESH;
            FUNC_RESET:   in_cmd.op = OP_RESET;
            FUNC_SCAN:    in_cmd.op = OP_SCAN;
            FUNC_QUERY:   in_cmd.op = OP_QUERY;
            default:      in_cmd.op = OP_BAD;
        endcase
    end

    assign req.ready = (count_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ cmd_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// File: sv/dtt_back.sv
module dtt_back
    import dtt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  cmd_t             cmd,
    output logic             cmd_pop,
    input  logic [PER_W-1:0] window,
    output logic             res_valid,
    output res_t             res,
    input  logic             res_ready
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_RESET2 = 6'b000100,
        S_SWEEP  = 6'b001000,
        S_POST   = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [TIMER_SLOTS-1:0] active_reg, active_next;
    logic [TIMER_SLOTS-1:0] reload_reg, reload_next;
    logic [TIMER_SLOTS-1:0] hit_reg, hit_next;
    logic [PER_W-1:0]       period_reg [TIMER_SLOTS];
    logic [TIME_W-1:0]      deadline_reg [TIMER_SLOTS];
    logic [TIME_W-1:0]      last_scan_reg, last_scan_next;
    logic                   pending_reg, pending_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic                   bv_reg, bv_next;
    logic [SLOT_W-1:0]      best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]      best_dl_reg, best_dl_next;
    logic                   emit_reg, emit_next;
    logic                   mark_reg, mark_next;
    logic                   roll_reg, roll_next;
    logic [SLOT_W-1:0]      target_reg, target_next;
    logic [TIME_W-1:0]      start_reg, start_next;
    res_t                   pend_reg, pend_next;
    res_t                   out_reg, out_next;
    logic                   out_vld_reg, out_vld_next;

    logic                   per_we, dl_we;
    logic [SLOT_W-1:0]      per_wa, dl_wa;
    logic [PER_W-1:0]       per_wd;
    logic [TIME_W-1:0]      dl_wd;
    logic [SLOT_W-1:0]      rd_addr;
    logic [PER_W-1:0]       per_rd;
    logic [TIME_W-1:0]      dl_rd;
    logic [SLOT_W-1:0]      free_idx;
    logic                   out_free;
    logic                   cand;
    logic                   ntf;
    logic [TIMER_SLOTS-1:0] rest;

    function automatic logic [SLOT_W-1:0] lowest_free(input logic [TIMER_SLOTS-1:0] act);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!act[i])
            begin
                r = SLOT_W'(i);
            end
        end
        return r;
    endfunction

    assign res_valid = out_vld_reg;
    assign res       = out_reg;
    assign out_free  = !out_vld_reg || res_ready;
    assign free_idx  = lowest_free(active_reg);

    // single table read port, address set by the step in progress
    always_comb
    begin
        priority case (1'b1)
            state_reg[3'd3]: rd_addr = idx_reg;
            state_reg[3'd4]: rd_addr = best_idx_reg;
            default:         rd_addr = cmd_reg.slot;
        endcase
    end
    assign per_rd = period_reg[rd_addr];
    assign dl_rd  = deadline_reg[rd_addr];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        active_next    = active_reg;
        reload_next    = reload_reg;
        hit_next       = hit_reg;
        last_scan_next = last_scan_reg;
        pending_next   = pending_reg;
        idx_next       = idx_reg;
        bv_next        = bv_reg;
        best_idx_next  = best_idx_reg;
        best_dl_next   = best_dl_reg;
        emit_next      = emit_reg;
        mark_next      = mark_reg;
        roll_next      = roll_reg;
        target_next    = target_reg;
        start_next     = start_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_vld_next   = out_vld_reg && !res_ready;
        per_we         = 1'b0;
        per_wa         = cmd_reg.slot;
        per_wd         = cmd_reg.period;
        dl_we          = 1'b0;
        dl_wa          = cmd_reg.slot;
        dl_wd          = cmd_reg.now + {{(TIME_W-PER_W){1'b0}}, cmd_reg.period};
        cmd_pop        = 1'b0;
        cand           = 1'b0;
        ntf            = 1'b0;
        rest           = hit_reg & ~(TIMER_SLOTS'(1) << best_idx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    cmd_pop    = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                pend_next  = mk_res(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1);
                state_next = S_OUT;
                idx_next   = '0;
                bv_next    = 1'b0;
                emit_next  = 1'b0;
                mark_next  = 1'b0;
                unique case (cmd_reg.op)
                    OP_ADD:
                    begin
                        if (&active_reg)
                        begin
                            pend_next.status = ST_FULL;
                        end
                        else
                        begin
                            active_next[free_idx] = 1'b1;
                            reload_next[free_idx] = cmd_reg.reload;
                            per_we      = 1'b1;
                            per_wa      = free_idx;
                            dl_we       = 1'b1;
                            dl_wa       = free_idx;
                            target_next = free_idx;
                            state_next  = S_SWEEP;
                        end
                    end
                    OP_CANCEL:
                    begin
                        if (!active_reg[cmd_reg.slot])
                            pend_next.status = ST_FAIL;
                        else
                            active_next[cmd_reg.slot] = 1'b0;
                    end
                    OP_REFRESH:
                    begin
                        if (!active_reg[cmd_reg.slot])
                        begin
                            pend_next.status = ST_FAIL;
                        end
                        else
                        begin
                            dl_we = 1'b1;
                            dl_wd = cmd_reg.now + {{(TIME_W-PER_W){1'b0}}, per_rd};
                        end
                    end
                    OP_RESET:
                    begin
                        // unchanged period without restart: nothing to do
                        if (per_rd == cmd_reg.period && !cmd_reg.restart)
                        begin
                            pend_next.status = ST_OK;
                        end
                        else if (!active_reg[cmd_reg.slot])
                        begin
                            pend_next.status = ST_FAIL;
                        end
                        else
                        begin
                            start_next = cmd_reg.restart ? cmd_reg.now :
                                         dl_rd - {{(TIME_W-PER_W){1'b0}}, per_rd};
                            state_next = S_RESET2;
                        end
                    end
                    OP_SCAN:
                    begin
                        if (|active_reg)
                        begin
                            roll_next  = (cmd_reg.now < last_scan_reg) &&
                                         ((last_scan_reg - cmd_reg.now) >
                                          {{(TIME_W-PER_W){1'b0}}, window});
                            hit_next   = '0;
                            mark_next  = 1'b1;
                            state_next = S_SWEEP;
                        end
                    end
                    OP_QUERY:
                    begin
                        pending_next = 1'b0;
                        state_next   = S_SWEEP;
                    end
                    default:
                    begin
                        pend_next.status = ST_FAIL;
                    end
                endcase
            end
            S_RESET2:
            begin
                per_we      = 1'b1;
                dl_we       = 1'b1;
                dl_wd       = start_reg + {{(TIME_W-PER_W){1'b0}}, cmd_reg.period};
                target_next = cmd_reg.slot;
                state_next  = S_SWEEP;
            end
            S_SWEEP:
            begin
                // one slot per cycle; ties keep the lower slot
                cand = emit_reg ? hit_reg[idx_reg] : active_reg[idx_reg];
                if (mark_reg)
                    hit_next[idx_reg] = active_reg[idx_reg] &&
                                        (roll_reg || dl_rd <= cmd_reg.now);
                if (cand && (!bv_reg || dl_rd < best_dl_reg))
                begin
                    bv_next       = 1'b1;
                    best_idx_next = idx_reg;
                    best_dl_next  = dl_rd;
                end
                if (idx_reg == SLOT_W'(TIMER_SLOTS - 1))
                    state_next = S_POST;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_POST:
            begin
                pend_next  = mk_res(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1);
                state_next = S_OUT;
                unique case (cmd_reg.op)
                    OP_ADD, OP_RESET:
                    begin
                        ntf = bv_reg && best_idx_reg == target_reg && !pending_reg;
                        if (ntf)
                            pending_next = 1'b1;
                        pend_next.notify = ntf;
                        if (cmd_reg.op == OP_ADD)
                            pend_next.slot = target_reg;
                    end
                    OP_QUERY:
                    begin
                        if (!bv_reg)
                            pend_next.wait_ms = '1;
                        else if (cmd_reg.now >= best_dl_reg)
                            pend_next.wait_ms = '0;
                        else
                            pend_next.wait_ms = best_dl_reg - cmd_reg.now;
                    end
                    OP_SCAN:
                    begin
                        if (!emit_reg)
                        begin
                            last_scan_next = cmd_reg.now;
                            if (hit_reg != '0)
                            begin
                                emit_next  = 1'b1;
                                mark_next  = 1'b0;
                                idx_next   = '0;
                                bv_next    = 1'b0;
                                state_next = S_SWEEP;
                            end
                        end
                        else
                        begin
                            // emit earliest due slot, then rearm or free it
                            pend_next = mk_res(ST_OK, best_idx_reg, 1'b1, '0, 1'b0,
                                               rest == '0);
                            hit_next  = rest;
                            if (reload_reg[best_idx_reg])
                            begin
                                dl_we = 1'b1;
                                dl_wa = best_idx_reg;
                                dl_wd = cmd_reg.now + {{(TIME_W-PER_W){1'b0}}, per_rd};
                            end
                            else
                            begin
                                active_next[best_idx_reg] = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        pend_next.status = ST_FAIL;
                    end
                endcase
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_next     = pend_reg;
                    out_vld_next = 1'b1;
                    if (pend_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        bv_next    = 1'b0;
                        state_next = S_SWEEP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            reload_reg    <= '0;
            hit_reg       <= '0;
            last_scan_reg <= '0;
            pending_reg   <= 1'b0;
            idx_reg       <= '0;
            bv_reg        <= 1'b0;
            emit_reg      <= 1'b0;
            mark_reg      <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            reload_reg    <= reload_next;
            hit_reg       <= hit_next;
            last_scan_reg <= last_scan_next;
            pending_reg   <= pending_next;
            idx_reg       <= idx_next;
            bv_reg        <= bv_next;
            emit_reg      <= emit_next;
            mark_reg      <= mark_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        roll_reg     <= roll_next;
        target_reg   <= target_next;
        start_reg    <= start_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        if (per_we)
            period_reg[per_wa] <= per_wd;
        if (dl_we)
            deadline_reg[dl_wa] <= dl_wd;
    end

endmodule

// File: sv/dtt_checker.sv
module dtt_prop_checker
    import dtt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] status,
    input logic       expired_valid,
    input logic       front_notify,
    input logic       last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status == ST_OK || status == ST_FAIL || status == ST_FULL)
        else $error("illegal status code");

    a_notify: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && front_notify |-> status == ST_OK && !expired_valid && last)
        else $error("notify on a failed or scan beat");

    a_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> expired_valid && status == ST_OK)
        else $error("non-final beat without expired slot");

endmodule

bind deadline_timer_table_unit dtt_prop_checker u_dtt_prop_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .expired_valid (rsp.expired_valid),
    .front_notify  (rsp.front_notify),
    .last          (rsp.last)
);

// File: dv/dtt_checker.sv
`timescale 1ns / 1ps

module dtt_checker
    import dtt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    dtt_req_if                req,
    dtt_rsp_if                rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                fail_count,
    output int                pending,
    output logic [TIMER_SLOTS-1:0] period_known
);

    // mirror of the timer table
    logic              act    [TIMER_SLOTS];
    logic              rearm  [TIMER_SLOTS];
    logic [PER_W-1:0]  per    [TIMER_SLOTS];
    logic [TIME_W-1:0] due_at [TIMER_SLOTS];
    logic [TIME_W-1:0] last_scan;
    logic              front_pend;
    logic [PER_W-1:0]  roll_win;

    res_t due_q[$];

    function automatic void add_beat(input res_t r);
        due_q = {due_q, r};
    endfunction

    function automatic bit ahead(int a, int b);
        if (due_at[a] != due_at[b])
            return due_at[a] < due_at[b];
        return a < b;
    endfunction

    function automatic int front_slot();
        int best;
        best = TIMER_SLOTS;
        for (int i = 0; i < TIMER_SLOTS; i++)
            if (act[i] && (best == TIMER_SLOTS || ahead(i, best)))
                best = i;
        return best;
    endfunction

    function automatic logic front_note(int s);
        if (front_slot() == s && !front_pend)
        begin
            front_pend = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_timer_op(input logic [2:0] f, input logic [SLOT_W-1:0] s,
                                    input logic [PER_W-1:0] p, input logic rl,
                                    input logic fn, input logic [TIME_W-1:0] t);
        int i;
        int best;
        int total;
        logic hit [TIMER_SLOTS];
        logic roll;
        logic [TIME_W-1:0] start;
        case (f)
            FUNC_ADD:
            begin
                for (i = 0; i < TIMER_SLOTS; i++)
                    if (!act[i])
                        break;
                if (i == TIMER_SLOTS)
                    add_beat(mk_res(ST_FULL, '0, 1'b0, '0, 1'b0, 1'b1));
                else
                begin
                    act[i]    = 1'b1;
                    rearm[i]  = rl;
                    per[i]    = p;
                    due_at[i] = t + p;
                    period_known[i] = 1'b1;
                    add_beat(mk_res(ST_OK, SLOT_W'(i), 1'b0, '0, front_note(i), 1'b1));
                end
            end
            FUNC_CANCEL:
            begin
                if (!act[s])
                    add_beat(mk_res(ST_FAIL, '0, 1'b0, '0, 1'b0, 1'b1));
                else
                begin
                    act[s] = 1'b0;
                    add_beat(mk_res(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1));
                end
            end
            FUNC_REFRESH:
            begin
                if (!act[s])
                    add_beat(mk_res(ST_FAIL, '0, 1'b0, '0, 1'b0, 1'b1));
                else
                begin
                    due_at[s] = t + per[s];
                    add_beat(mk_res(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1));
                end
            end
            FUNC_RESET:
            begin
                if (per[s] == p && !fn)
                    add_beat(mk_res(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1));
                else if (!act[s])
                    add_beat(mk_res(ST_FAIL, '0, 1'b0, '0, 1'b0, 1'b1));
                else
                begin
                    start     = fn ? t : due_at[s] - per[s];
                    per[s]    = p;
                    due_at[s] = start + p;
                    add_beat(mk_res(ST_OK, '0, 1'b0, '0, front_note(s), 1'b1));
                end
            end
            FUNC_SCAN:
            begin
                if (front_slot() == TIMER_SLOTS)
                    add_beat(mk_res(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1));
                else
                begin
                    roll = t < last_scan && (last_scan - t) > {32'b0, roll_win};
                    last_scan = t;
                    total = 0;
                    for (i = 0; i < TIMER_SLOTS; i++)
                    begin
                        hit[i] = act[i] && (roll || due_at[i] <= t);
                        if (hit[i])
                            total++;
                    end
                    if (total == 0)
                        add_beat(mk_res(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1));
                    for (int k = 0; k < total; k++)
                    begin
                        best = TIMER_SLOTS;
                        for (i = 0; i < TIMER_SLOTS; i++)
                            if (hit[i] && (best == TIMER_SLOTS || ahead(i, best)))
                                best = i;
                        hit[best] = 1'b0;
                        add_beat(mk_res(ST_OK, SLOT_W'(best), 1'b1, '0, 1'b0,
                                        k == total - 1));
                    end
                    // rearm only after the ordering above is fixed
                    for (i = 0; i < TIMER_SLOTS; i++)
                        if (act[i] && (roll || due_at[i] <= t))
                        begin
                            if (rearm[i])
                                due_at[i] = t + per[i];
                            else
                                act[i] = 1'b0;
                        end
                end
            end
            FUNC_QUERY:
            begin
                best = front_slot();
                front_pend = 1'b0;
                if (best == TIMER_SLOTS)
                    add_beat(mk_res(ST_OK, '0, 1'b0, '1, 1'b0, 1'b1));
                else if (t >= due_at[best])
                    add_beat(mk_res(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1));
                else
                    add_beat(mk_res(ST_OK, '0, 1'b0, due_at[best] - t, 1'b0, 1'b1));
            end
            default:
                add_beat(mk_res(ST_FAIL, '0, 1'b0, '0, 1'b0, 1'b1));
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        period_known = '0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TIMER_SLOTS; i++)
            begin
                act[i]   = 1'b0;
                rearm[i] = 1'b0;
            end
            last_scan  = '0;
            front_pend = 1'b0;
            roll_win   = ROLLOVER_RESET;
            due_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_ROLLOVER)
                roll_win = pwdata;
            if (rsp.valid && rsp.ready)
            begin
                if (due_q.size() == 0)
                    report_mismatch("unexpected beat, slot", rsp.result_slot, '0);
                else
                begin
                    want = due_q.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.result_slot !== want.slot)
                        report_mismatch("result_slot", rsp.result_slot, want.slot);
                    if (rsp.expired_valid !== want.expired)
                        report_mismatch("expired_valid", rsp.expired_valid, want.expired);
                    if (rsp.wait_ms !== want.wait_ms)
                        report_mismatch("wait_ms", rsp.wait_ms, want.wait_ms);
                    if (rsp.front_notify !== want.notify)
                        report_mismatch("front_notify", rsp.front_notify, want.notify);
                    if (rsp.last !== want.last)
                        report_mismatch("last", rsp.last, want.last);
                end
            end
            if (req.valid && req.ready)
                predict_timer_op(req.func, req.timer_slot, req.period_ms, req.reload,
                                 req.restart_from_now, req.now_ms);
        end
        pending = due_q.size();
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dtt_pkg::*;

    localparam logic [2:0] FUNC_BAD_LO = 3'd6;
    localparam logic [2:0] FUNC_BAD_HI = 3'd7;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 44;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata, prdata;

    int fail_count;
    int pending;
    logic [TIMER_SLOTS-1:0] period_known;

    int tx_idle;
    int rx_idle;
    logic rx_hold;
    int quiet_cycles;
    logic [TIME_W-1:0] tnow;

    dtt_req_if req_if();
    dtt_rsp_if rsp_if();

    deadline_timer_table_unit dut (
        .clk(clk), .rst_n(rst_n), .req(req_if), .rsp(rsp_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    dtt_checker checker_i (
        .clk(clk), .rst_n(rst_n), .req(req_if), .rsp(rsp_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
        .pending(pending), .period_known(period_known)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(negedge clk)
        rsp_if.ready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_idle);

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_op(input logic [2:0] f, input logic [SLOT_W-1:0] s,
                           input logic [PER_W-1:0] p, input logic rl, input logic fn,
                           input logic [TIME_W-1:0] t);
        if ($urandom_range(99) < tx_idle)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < tx_idle)
                @(negedge clk);
        end
        req_if.valid            <= 1'b1;
        req_if.func             <= f;
        req_if.timer_slot       <= s;
        req_if.period_ms        <= p;
        req_if.reload           <= rl;
        req_if.restart_from_now <= fn;
        req_if.now_ms           <= t;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_window(input logic [31:0] v);
        drain_results();
        repeat (40) @(negedge clk);   // let the executor settle
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ROLLOVER;
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_op();
        int pick;
        logic [2:0] f;
        logic [SLOT_W-1:0] s;
        logic [PER_W-1:0] p;
        pick = $urandom_range(99);
        // time mostly creeps forward, with rare jumps back and wild values
        if (pick < 3)
            tnow = tnow - $urandom_range(8000);
        else if (pick < 5)
            tnow = {$urandom, $urandom};
        else
            tnow = tnow + $urandom_range(60);
        p = ($urandom_range(9) == 0) ? $urandom : $urandom_range(150);
        s = SLOT_W'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 30)
            f = FUNC_ADD;
        else if (pick < 42)
            f = FUNC_CANCEL;
        else if (pick < 52)
            f = FUNC_REFRESH;
        else if (pick < 65)
            f = FUNC_RESET;
        else if (pick < 85)
            f = FUNC_SCAN;
        else if (pick < 97)
            f = FUNC_QUERY;
        else
            f = $urandom_range(1) ? FUNC_BAD_LO : FUNC_BAD_HI;
        if (f == FUNC_RESET)
        begin
            // a reset may only touch slots whose period was set
            if (period_known == '0)
                f = FUNC_ADD;
            else
                while (!period_known[s])
                    s = SLOT_W'($urandom_range(15));
        end
        send_op(f, s, p, 1'($urandom_range(1)), 1'($urandom_range(1)), tnow);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.func = FUNC_ADD;
        req_if.timer_slot = '0;
        req_if.period_ms = '0;
        req_if.reload = 1'b0;
        req_if.restart_from_now = 1'b0;
        req_if.now_ms = '0;
        rsp_if.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rx_hold = 1'b0;
        quiet_cycles = 0;
        tx_idle = 22;
        rx_idle = 68;
        tnow = 64'd100;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed
        send_op(FUNC_SCAN, 4'd0, 32'd0, 1'b0, 1'b0, 64'd50);
        send_op(FUNC_QUERY, 4'd0, 32'd0, 1'b0, 1'b0, 64'd50);
        send_op(FUNC_ADD, 4'd0, 32'd0, 1'b0, 1'b0, 64'd100);
        send_op(FUNC_ADD, 4'd15, 32'hffff_ffff, 1'b1, 1'b1, 64'd100);
        send_op(FUNC_QUERY, 4'd0, 32'd0, 1'b0, 1'b0, 64'd90);
        send_op(FUNC_CANCEL, 4'd15, 32'd0, 1'b0, 1'b0, 64'd100);
        send_op(FUNC_REFRESH, 4'd0, 32'd0, 1'b0, 1'b0, 64'd120);
        send_op(FUNC_REFRESH, 4'd9, 32'd0, 1'b0, 1'b0, 64'd120);
        send_op(FUNC_RESET, 4'd1, 32'hffff_ffff, 1'b0, 1'b0, 64'd130);
        send_op(FUNC_RESET, 4'd1, 32'd40, 1'b0, 1'b1, 64'd130);
        send_op(FUNC_RESET, 4'd0, 32'd5, 1'b0, 1'b0, 64'd140);
        send_op(FUNC_QUERY, 4'd0, 32'd0, 1'b0, 1'b0, 64'd140);
        send_op(FUNC_BAD_LO, 4'd3, 32'd7, 1'b1, 1'b1, 64'd140);
        send_op(FUNC_BAD_HI, 4'd3, 32'd7, 1'b1, 1'b1, 64'd140);
        send_op(FUNC_SCAN, 4'd0, 32'd0, 1'b0, 1'b0, 64'd200);
        send_op(FUNC_ADD, 4'd0, 32'd10, 1'b1, 1'b0, 64'hffff_ffff_ffff_fff0);
        send_op(FUNC_SCAN, 4'd0, 32'd0, 1'b0, 1'b0, 64'hffff_ffff_ffff_ffff);
        send_op(FUNC_SCAN, 4'd0, 32'd0, 1'b0, 1'b0, 64'd0);
        send_op(FUNC_CANCEL, 4'd0, 32'd0, 1'b0, 1'b0, 64'd0);
        write_window(32'd0);
        for (int i = 0; i < TIMER_SLOTS + 1; i++)
            send_op(FUNC_ADD, 4'd0, 32'd3, i[0], 1'b0, 64'd10);
        send_op(FUNC_SCAN, 4'd0, 32'd0, 1'b0, 1'b0, 64'd5);

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle = (ph == 0) ? 22 : (ph == 1) ? 68 : 0;
            rx_idle = (ph == 0) ? 68 : (ph == 1) ? 22 : 0;
            write_window((ph == 0) ? 32'hffff_ffff : (ph == 1) ? 32'd500 : $urandom);
            tnow = 64'd1000;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 0 && n == 8)
                    fork
                        begin
                            rx_hold = 1'b1;
                            repeat (400) @(negedge clk);
                            rx_hold = 1'b0;
                        end
                    join_none
                if (ph == 1 && n == 20)
                    drain_results();
                random_op();
            end
        end
        write_window(ROLLOVER_RESET);
        send_op(FUNC_QUERY, 4'd0, 32'd0, 1'b0, 1'b0, tnow);

        drain_results();
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
